@@ rtl/assert_macros.svh @@
// Assertion macros for the RTL; the top-level unit includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	`ASSERT_AT(label, clk, rst_n, !(expr), msg)

`endif

@@ rtl/spwt_pkg.sv @@
// Package: types, codes and constants of the stream pattern wait unit.
`default_nettype none

package spwt_pkg;

	// Defaults of the top-level parameters
	localparam int MAX_PATTERN_DEF  = 16;
	localparam int BUFFER_LIMIT_DEF = 1024;

	// Field and register widths
	localparam int BYTE_W    = 8;
	localparam int CHAR_W    = 7;
	localparam int PAT_BYTES = 16;
	localparam int PIDX_W    = $clog2(PAT_BYTES);
	localparam int CFG_W     = 64;
	localparam int LEN_W     = 5;
	localparam int TICK_W    = 32;
	localparam int STORED_W  = 11;
	localparam int STATUS_W  = 2;

	// Register reset values
	localparam logic [LEN_W-1:0]  LEN_RST     = LEN_W'(1);
	localparam logic [TICK_W-1:0] TIMEOUT_RST = TICK_W'(600);

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_PAT_LO  = 2'd0,
		REG_PAT_HI  = 2'd1,
		REG_PAT_LEN = 2'd2,
		REG_TIMEOUT = 2'd3
	} cfg_reg_t;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_WAIT     = 2'd0,
		ST_MATCH    = 2'd1,
		ST_TIMEOUT  = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

	typedef logic [PAT_BYTES-1:0][BYTE_W-1:0] pattern_t;

endpackage

`default_nettype wire

@@ rtl/spwt_match.sv @@
// Window compare: checks the newest stored characters against the pattern.
`default_nettype none

module spwt_match
	import spwt_pkg::*;
#(
	parameter int MAX_PATTERN = MAX_PATTERN_DEF,
	parameter int CNT_W       = 11
) (
	input  wire pattern_t                            pattern,
	input  wire logic [LEN_W-1:0]                    pattern_length,
	input  wire logic [MAX_PATTERN-1:0][CHAR_W-1:0]  window,
	input  wire logic [CNT_W-1:0]                    count,
	output logic                                     match
);

	localparam int LW = $clog2(MAX_PATTERN + 1);

	logic [LW-1:0] len_c;
	logic          mismatch;

	// Lengths above the window depth count as the full window
	always_comb begin
		if (32'(pattern_length) > 32'(MAX_PATTERN)) begin
			len_c = LW'(MAX_PATTERN);
		end else begin
			len_c = LW'(pattern_length);
		end
	end

	// Newest character (entry 0) lines up with the last pattern byte
	always_comb begin
		logic [31:0]      pidx;
		logic [BYTE_W-1:0] pbyte;
		mismatch = 1'b0;
		for (int k = 0; k < MAX_PATTERN; k++) begin
			pidx = 32'(len_c) - 32'd1 - 32'(k);
			// bytes past the pattern registers never match a stored character
			if (pidx < 32'(PAT_BYTES)) begin
				pbyte = pattern[PIDX_W'(pidx)];
			end else begin
				pbyte = '0;
			end
			if ((32'(k) < 32'(len_c)) && (pbyte != {1'b0, window[k]})) begin
				mismatch = 1'b1;
			end
		end
	end

	assign match = (len_c == '0) ||
		((32'(count) >= 32'(len_c)) && !mismatch);

endmodule

`default_nettype wire

@@ rtl/stream_pattern_wait_with_timeout_unit.sv @@
// Stream pattern wait unit: pattern search over a byte stream with tick timeout.
//
// Each input transaction is either a received byte (action 0) or one timer tick
// (action 1) and yields exactly one result: the status (waiting, matched, timed
// out, overflow) and the count of nonzero 7-bit characters stored so far. A
// match is the newest pattern_length characters equal to the pattern; overflow
// wins when the count reaches BUFFER_LIMIT; the first terminal status holds
// until reset. The unit takes one transaction per clock cycle while out_ready
// does not stall the result channel; a result passes from the input register
// to the result register once that register is free or being taken, with the
// window compare and status update done combinationally between the registers.
// Configuration writes take effect at once.
`default_nettype none

module stream_pattern_wait_with_timeout_unit
	import spwt_pkg::*;
#(
	parameter int MAX_PATTERN  = MAX_PATTERN_DEF,
	parameter int BUFFER_LIMIT = BUFFER_LIMIT_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// configuration
	input  wire logic                 cfg_wr_en,
	input  wire logic [1:0]           cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	// input channel
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic                 action,
	input  wire logic [BYTE_W-1:0]    rx_byte,
	// result channel
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [STATUS_W-1:0]       status,
	output logic [STORED_W-1:0]       bytes_stored
);

	`include "assert_macros.svh"

	localparam int CNT_W = $clog2(BUFFER_LIMIT + 1);

	// Configuration registers
	logic [CFG_W-1:0]  pat_lo_q;
	logic [CFG_W-1:0]  pat_hi_q;
	logic [LEN_W-1:0]  pat_len_q;
	logic [TICK_W-1:0] timeout_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q  <= '0;
			pat_hi_q  <= '0;
			pat_len_q <= LEN_RST;
			timeout_q <= TIMEOUT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_PAT_LO:  pat_lo_q  <= cfg_data;
				REG_PAT_HI:  pat_hi_q  <= cfg_data;
				REG_PAT_LEN: pat_len_q <= cfg_data[LEN_W-1:0];
				REG_TIMEOUT: timeout_q <= cfg_data[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	// Input register stage
	logic              valid_s1;
	logic              action_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              out_valid_q;
	logic              go_s1;

	assign go_s1    = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			action_s1 <= action;
			char_s1   <= rx_byte[CHAR_W-1:0];
		end
	end

	// Search state
	logic [MAX_PATTERN-1:0][CHAR_W-1:0] win_q;
	logic [MAX_PATTERN-1:0][CHAR_W-1:0] win_n;
	logic [CNT_W-1:0]                   cnt_q;
	logic [CNT_W-1:0]                   cnt_n;
	logic [TICK_W-1:0]                  ticks_q;
	logic [TICK_W-1:0]                  ticks_n;
	logic [TICK_W-1:0]                  ticks_inc;
	status_t                            stat_q;
	status_t                            stat_n;
	logic                               char_ok;
	logic                               store;
	logic                               match;

	assign char_ok = (char_s1 != '0);

	// Window shifted by the new character, newest in entry 0
	for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_shift
		if (k == 0) begin : g_head
			assign win_n[k] = char_s1;
		end else begin : g_tail
			assign win_n[k] = win_q[k-1];
		end
	end

	assign cnt_n     = cnt_q + CNT_W'(1);
	assign ticks_inc = (ticks_q == '1) ? ticks_q : ticks_q + TICK_W'(1);

	spwt_match #(
		.MAX_PATTERN(MAX_PATTERN),
		.CNT_W      (CNT_W)
	) u_match (
		.pattern       (pattern_t'({pat_hi_q, pat_lo_q})),
		.pattern_length(pat_len_q),
		.window        (char_ok ? win_n : win_q),
		.count         (char_ok ? cnt_n : cnt_q),
		.match         (match)
	);

	// Status update for the transaction in the input stage
	always_comb begin
		stat_n  = stat_q;
		ticks_n = ticks_q;
		store   = 1'b0;
		if (stat_q == ST_WAIT) begin
			if (ticks_q >= timeout_q) begin
				stat_n = ST_TIMEOUT;
			end else if (action_s1) begin
				ticks_n = ticks_inc;
				if (ticks_inc >= timeout_q) begin
					stat_n = ST_TIMEOUT;
				end
			end else begin
				store = char_ok;
				if (32'(char_ok ? cnt_n : cnt_q) >= 32'(BUFFER_LIMIT)) begin
					stat_n = ST_OVERFLOW;
				end else if (match) begin
					stat_n = ST_MATCH;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q   <= '0;
			cnt_q   <= '0;
			ticks_q <= '0;
			stat_q  <= ST_WAIT;
		end else if (go_s1) begin
			if (store) begin
				win_q <= win_n;
				cnt_q <= cnt_n;
			end
			ticks_q <= ticks_n;
			stat_q  <= stat_n;
		end
	end

	// Result register
	logic [31:0]         cnt_ext;
	logic [STATUS_W-1:0] status_q;
	logic [STORED_W-1:0] stored_q;

	assign cnt_ext = 32'(store ? cnt_n : cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1) begin
			status_q <= stat_n;
			stored_q <= cnt_ext[STORED_W-1:0];
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign bytes_stored = stored_q;

	// Checks
	`ASSERT_AT(a_terminal_holds, clk, arst_n,
		(stat_q != ST_WAIT) |=> (stat_q == $past(stat_q)), "terminal status changed")
	`ASSERT_NEVER(a_count_bound, clk, arst_n,
		32'(cnt_q) > 32'(BUFFER_LIMIT), "stored count above buffer limit")
	`ASSERT_AT(a_overflow_count, clk, arst_n,
		(stat_q == ST_OVERFLOW) |-> (32'(cnt_q) == 32'(BUFFER_LIMIT)),
		"overflow without full count")
	`ASSERT_AT(a_state_idle, clk, arst_n,
		!go_s1 |=> ($stable(cnt_q) && $stable(ticks_q) && $stable(stat_q)),
		"state moved without a transaction")
	`ASSERT_AT(a_result_follows, clk, arst_n,
		go_s1 |=> out_valid, "processed transaction gave no result")

endmodule

`default_nettype wire

@@ tb/tb_stream_pattern_wait_with_timeout_unit.sv @@
// Testbench for the stream pattern wait unit: directed cases, search traffic, one terminal ending.
`default_nettype none

module tb_stream_pattern_wait_with_timeout_unit
	import spwt_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RESULT_LATENCY = 2;

	// Predicted search state, one copy beside the DUT
	typedef struct packed {
		logic [PAT_BYTES-1:0][CHAR_W-1:0] window;   // index 0 is the newest char
		logic [31:0]                      stored;
		logic [TICK_W-1:0]                elapsed;
		status_t                          state;
	} search_state_t;

	typedef struct packed {
		status_t             status;
		logic [STORED_W-1:0] count;
	} search_result_t;

	typedef enum int unsigned {
		END_MATCH,
		END_EMPTY,
		END_TICKS,
		END_BUDGET,
		END_OVERFLOW
	} search_end_t;

	// DUT inputs, all known from time zero
	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_wr_en = 1'b0;
	logic [1:0]          cfg_index = REG_PAT_LO;
	logic [CFG_W-1:0]    cfg_data = '0;
	logic                in_valid = 1'b0;
	logic                action = 1'b0;
	logic [BYTE_W-1:0]   rx_byte = '0;
	logic                out_ready = 1'b0;
	// DUT outputs
	logic                in_ready;
	logic                out_valid;
	logic [STATUS_W-1:0] status;
	logic [STORED_W-1:0] bytes_stored;

	// Register copies at their reset values
	logic [CFG_W-1:0]  pat_lo_q = '0;
	logic [CFG_W-1:0]  pat_hi_q = '0;
	logic [LEN_W-1:0]  pat_len_q = LEN_RST;
	logic [TICK_W-1:0] timeout_q = TIMEOUT_RST;

	search_state_t  search = '0;
	search_result_t pending_results[$];
	search_result_t got_want;
	search_end_t    ending_pick;
	bit             keep_waiting = 1'b1;
	int             fail_count = 0;
	int             drain_wait = 0;
	int unsigned    tx_steady = 0;
	int unsigned    rx_hold = 0;
	int unsigned    rx_roll;

	stream_pattern_wait_with_timeout_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.bytes_stored (bytes_stored)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Pattern byte idx as configured, bit 7 included
	function automatic logic [BYTE_W-1:0] pat_byte(input int idx);
		logic [2*CFG_W-1:0] all_bytes;
		all_bytes = {pat_hi_q, pat_lo_q};
		return all_bytes[8*idx +: 8];
	endfunction

	// Lengths above the window depth count as the full window
	function automatic int eff_len();
		return (pat_len_q > PAT_BYTES) ? PAT_BYTES : int'(pat_len_q);
	endfunction

	function automatic bit window_hit(input search_state_t s);
		int len;
		len = eff_len();
		if (len == 0)
			return 1'b1;
		if (s.stored < len)
			return 1'b0;
		for (int k = 0; k < len; k++) begin
			if ({1'b0, s.window[k]} != pat_byte(len - 1 - k))
				return 1'b0;
		end
		return 1'b1;
	endfunction

	// Next search state after one transaction
	function automatic search_state_t next_search_state(input search_state_t s, input logic act,
			input logic [BYTE_W-1:0] b);
		search_state_t     n;
		logic [CHAR_W-1:0] ch;
		n = s;
		ch = b[CHAR_W-1:0];
		if (n.state == ST_WAIT) begin
			if (n.elapsed >= timeout_q) begin
				n.state = ST_TIMEOUT;
			end else if (act) begin
				if (n.elapsed != '1)
					n.elapsed = n.elapsed + 1'b1;
				if (n.elapsed >= timeout_q)
					n.state = ST_TIMEOUT;
			end else begin
				if (ch != '0) begin
					n.window = {n.window[PAT_BYTES-2:0], ch};
					n.stored = n.stored + 1;
				end
				if (n.stored >= BUFFER_LIMIT_DEF)
					n.state = ST_OVERFLOW;
				else if (window_hit(n))
					n.state = ST_MATCH;
			end
		end
		return n;
	endfunction

	// Sender gap: mostly none or short, a few long, some steady stretches
	function automatic int pick_gap();
		int unsigned roll;
		if (tx_steady != 0) begin
			tx_steady--;
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 5) begin
			tx_steady = $urandom_range(20, 60);
			return 0;
		end
		if (roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	// Register write, only while the unit is idle
	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_PAT_LO: pat_lo_q = value;
			REG_PAT_HI: pat_hi_q = value;
			REG_PAT_LEN: pat_len_q = value[LEN_W-1:0];
			REG_TIMEOUT: timeout_q = value[TICK_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// One input transaction; records the predicted result on acceptance
	task automatic send_item(input logic act, input logic [BYTE_W-1:0] b);
		int                gap;
		logic              act_use;
		logic [BYTE_W-1:0] b_use;
		logic [BYTE_W-1:0] last_pat;
		logic [CHAR_W-1:0] ch;
		search_result_t    res;
		search_state_t     trial;
		act_use = act;
		b_use = b;
		trial = next_search_state(search, act, b);
		// during traffic rounds a transaction that would end the search is swapped
		if (keep_waiting && trial.state != ST_WAIT) begin
			last_pat = pat_byte((eff_len() == 0) ? 0 : eff_len() - 1);
			ch = last_pat[CHAR_W-1:0] ^ 7'h01;
			if (ch == '0)
				ch = 7'h03;
			trial = next_search_state(search, 1'b0, {b[7], ch});
			if (trial.state == ST_WAIT) begin
				act_use = 1'b0;
				b_use = {b[7], ch};
			end else begin
				trial = next_search_state(search, 1'b1, b);
				if (trial.state == ST_WAIT)
					act_use = 1'b1;
			end
		end
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act_use;
		rx_byte <= b_use;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		search = next_search_state(search, act_use, b_use);
		res.status = search.state;
		res.count = search.stored[STORED_W-1:0];
		pending_results.push_back(res);
	endtask

	// Stop sending and let every expected result come out
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (RESULT_LATENCY + 1) @(posedge clk);
	endtask

	// Reset config: zero bytes, masked-to-zero bytes and ticks store nothing
	task automatic test_reset_defaults();
		send_item(1'b0, 8'h00);
		send_item(1'b0, 8'h80);
		send_item(1'b1, 8'h5a);
		send_item(1'b1, 8'ha5);
		wait_idle();
	endtask

	// Zero-filled window slots would match the pattern without the count guard
	task automatic test_too_few_stored();
		write_reg(REG_PAT_LEN, 64'd4);
		write_reg(REG_PAT_LO, 64'h41_00_00_00);
		send_item(1'b0, 8'h41);
		send_item(1'b0, 8'hc1);
		send_item(1'b0, 8'h41);
		send_item(1'b0, 8'h41);
		wait_idle();
	endtask

	// Pattern bytes with bit 7 set never match; over-long length counts as 16
	task automatic test_unmatchable_bytes();
		write_reg(REG_PAT_LEN, 64'd1);
		write_reg(REG_PAT_LO, 64'hc1);
		send_item(1'b0, 8'h41);
		send_item(1'b0, 8'hc1);
		wait_idle();
		write_reg(REG_PAT_LO, '1);
		write_reg(REG_PAT_HI, '0);
		write_reg(REG_PAT_LEN, 64'd31);
		write_reg(REG_TIMEOUT, 64'hffff_ffff);
		send_item(1'b0, 8'h7f);
		send_item(1'b0, 8'hff);
		send_item(1'b0, 8'h01);
		send_item(1'b0, 8'h00);
		send_item(1'b1, 8'hff);
		wait_idle();
	endtask

	// Random pattern, then pattern prefixes, broken prefixes and noise
	task automatic test_search_traffic(input int items);
		pattern_t          pat;
		int                len_cfg;
		int                eff;
		int                sent;
		int                roll;
		int                span;
		int                bad;
		bit                narrow;
		logic [BYTE_W-1:0] by;
		wait_idle();
		roll = $urandom_range(0, 99);
		if (roll < 70)
			len_cfg = $urandom_range(1, 16);
		else if (roll < 85)
			len_cfg = $urandom_range(17, 31);
		else
			len_cfg = 16;
		eff = (len_cfg > PAT_BYTES) ? PAT_BYTES : len_cfg;
		// a narrow alphabet gives self-overlapping patterns
		narrow = 1'($urandom_range(0, 1));
		for (int i = 0; i < PAT_BYTES; i++) begin
			if (i < eff && $urandom_range(0, 9) != 0)
				pat[i] = narrow ? 8'($urandom_range(8'h41, 8'h44)) : 8'($urandom_range(1, 127));
			else
				pat[i] = 8'($urandom);
		end
		write_reg(REG_PAT_LO, pat[7:0]);
		write_reg(REG_PAT_HI, pat[15:8]);
		write_reg(REG_PAT_LEN, CFG_W'(len_cfg));
		if ($urandom_range(0, 3) == 0)
			write_reg(REG_TIMEOUT, 64'hffff_ffff);
		else
			write_reg(REG_TIMEOUT, CFG_W'(search.elapsed + $urandom_range(400, 5000)));
		keep_waiting = 1'b1;
		sent = 0;
		while (sent < items) begin
			roll = $urandom_range(0, 99);
			span = $urandom_range(1, eff);
			bad = (roll < 60) ? -1 : $urandom_range(0, span - 1);
			if (roll < 80) begin
				for (int k = 0; k < span; k++) begin
					if ($urandom_range(0, 7) == 0) begin
						send_item(1'($urandom_range(0, 1)), {1'($urandom_range(0, 1)), 7'h00});
						sent++;
					end
					by = pat_byte(k);
					if (k == bad)
						by = 8'($urandom);
					else
						by[7] = 1'($urandom_range(0, 1));
					send_item(1'b0, by);
					sent++;
				end
			end else begin
				repeat ($urandom_range(1, 8)) begin
					send_item(1'($urandom_range(0, 3) == 0), 8'($urandom));
					sent++;
				end
			end
			// now and then hold off until the unit has drained
			if ($urandom_range(0, 39) == 0)
				wait_idle();
		end
		wait_idle();
	endtask

	// Send a matchable pattern until it is found
	task automatic test_match_end();
		pattern_t pat;
		int       len_cfg;
		int       eff;
		int       k;
		wait_idle();
		len_cfg = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 31) : $urandom_range(1, 16);
		eff = (len_cfg > PAT_BYTES) ? PAT_BYTES : len_cfg;
		for (int i = 0; i < PAT_BYTES; i++)
			pat[i] = (i < eff) ? 8'($urandom_range(1, 127)) : 8'($urandom);
		write_reg(REG_PAT_LO, pat[7:0]);
		write_reg(REG_PAT_HI, pat[15:8]);
		write_reg(REG_PAT_LEN, CFG_W'(len_cfg));
		write_reg(REG_TIMEOUT, 64'hffff_ffff);
		keep_waiting = 1'b0;
		k = 0;
		while (search.state == ST_WAIT) begin
			if ($urandom_range(0, 7) == 0)
				send_item(1'($urandom_range(0, 1)), {1'($urandom_range(0, 1)), 7'h00});
			send_item(1'b0, {1'($urandom_range(0, 1)), pat[k][CHAR_W-1:0]});
			k = (k + 1) % eff;
		end
	endtask

	// Empty pattern: a tick does not match, any byte transaction does
	task automatic test_empty_pattern_end();
		wait_idle();
		write_reg(REG_TIMEOUT, 64'hffff_ffff);
		write_reg(REG_PAT_LEN, 64'd0);
		keep_waiting = 1'b0;
		send_item(1'b1, 8'($urandom));
		send_item(1'b0, 8'($urandom));
	endtask

	// Ticks run the budget out
	task automatic test_tick_timeout_end();
		wait_idle();
		write_reg(REG_PAT_LO, '1);
		write_reg(REG_PAT_HI, '1);
		write_reg(REG_PAT_LEN, 64'd16);
		write_reg(REG_TIMEOUT, CFG_W'(search.elapsed + $urandom_range(1, 8)));
		keep_waiting = 1'b0;
		while (search.state == ST_WAIT)
			send_item(1'($urandom_range(0, 2) != 0), 8'($urandom));
	endtask

	// Budget lowered to or below the ticks already counted, zero included
	task automatic test_budget_used_end();
		wait_idle();
		if ($urandom_range(0, 1) == 0)
			write_reg(REG_TIMEOUT, '0);
		else
			write_reg(REG_TIMEOUT, CFG_W'(search.elapsed));
		keep_waiting = 1'b0;
		send_item(1'($urandom_range(0, 1)), 8'($urandom));
	endtask

	// Store bytes until the buffer limit is hit
	task automatic test_overflow_end();
		wait_idle();
		write_reg(REG_PAT_LO, '1);
		write_reg(REG_PAT_HI, '1);
		write_reg(REG_PAT_LEN, 64'd16);
		write_reg(REG_TIMEOUT, 64'hffff_ffff);
		keep_waiting = 1'b0;
		while (search.state == ST_WAIT)
			send_item(1'($urandom_range(0, 9) == 0), 8'($urandom));
	endtask

	// Terminal status and count hold, register writes leave them alone
	task automatic test_held_status();
		keep_waiting = 1'b0;
		repeat (10) send_item(1'($urandom_range(0, 1)), 8'($urandom));
		wait_idle();
		write_reg(REG_TIMEOUT, CFG_W'($urandom));
		write_reg(REG_PAT_LEN, 64'd0);
		repeat (10) send_item(1'($urandom_range(0, 1)), 8'($urandom));
	endtask

	// Result side: ready in segments, mostly high, short and long stalls
	always @(posedge clk) begin
		if (rx_hold != 0) begin
			rx_hold <= rx_hold - 1;
		end else begin
			rx_roll = $urandom_range(0, 99);
			if (rx_roll < 60) begin
				out_ready <= 1'b1;
				rx_hold <= $urandom_range(0, 8);
			end else if (rx_roll < 70) begin
				out_ready <= 1'b1;
				rx_hold <= $urandom_range(40, 100);
			end else if (rx_roll < 95) begin
				out_ready <= 1'b0;
				rx_hold <= $urandom_range(0, 3);
			end else begin
				out_ready <= 1'b0;
				rx_hold <= $urandom_range(10, 40);
			end
		end
	end

	// Compare each result transaction with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: status %0d bytes_stored %0d", status, bytes_stored);
				fail_count++;
			end else begin
				got_want = pending_results.pop_front();
				if (status !== got_want.status) begin
					$error("status: expected %0d, actual %0d", got_want.status, status);
					fail_count++;
				end
				if (bytes_stored !== got_want.count) begin
					$error("bytes_stored: expected %0d, actual %0d", got_want.count, bytes_stored);
					fail_count++;
				end
			end
		end
	end

	// Main sequence
	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_too_few_stored();
		test_unmatchable_bytes();
		repeat (4) test_search_traffic(220);
		// the terminal status holds until reset, so one ending per run
		ending_pick = search_end_t'($urandom_range(0, 4));
		case (ending_pick)
			END_MATCH: test_match_end();
			END_EMPTY: test_empty_pattern_end();
			END_TICKS: test_tick_timeout_end();
			END_BUDGET: test_budget_used_end();
			default: test_overflow_end();
		endcase
		test_held_status();
		in_valid <= 1'b0;
		while (pending_results.size() != 0 && drain_wait < 5000) begin
			@(posedge clk);
			drain_wait++;
		end
		repeat (RESULT_LATENCY + 2) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d expected results never arrived", pending_results.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Run limit
	initial begin
		#8ms;
		$display("Regression FAIL");
		$finish;
	end

endmodule

`default_nettype wire
